// ----- rtl/core/vbe_pkg.sv -----
// Shared types and constants for the voxel brush edit block.
package vbe_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CENTER_BITS    = 16;
  localparam int SIZE_BITS      = 15;
  localparam int SEL_BITS       = 10;
  localparam int FLAT_BITS      = 11;
  localparam int RSQ_BITS       = 2 * SIZE_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTROL   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLAT      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_LOW   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEL_HIGH  = 3'd7;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_REPLACE = 3'd2,
    MODE_PAINT   = 3'd3,
    MODE_FLATTEN = 3'd4
  } mode_t;

  typedef struct packed {
    logic [15:0] vtype;
    logic [15:0] material;
    logic [7:0]  density;
  } voxel_t;

  typedef struct packed {
    logic [2:0]                    mode;
    logic                          box;
    logic                          sel_en;
    logic signed [CENTER_BITS-1:0] cx;
    logic signed [CENTER_BITS-1:0] cy;
    logic signed [CENTER_BITS-1:0] cz;
    logic [SIZE_BITS-1:0]          radius;
    logic [SIZE_BITS-1:0]          hx;
    logic [SIZE_BITS-1:0]          hy;
    logic [SIZE_BITS-1:0]          hz;
    voxel_t                        fill;
    logic signed [FLAT_BITS-1:0]   flat_h;
    logic [SEL_BITS-1:0]           lo_x;
    logic [SEL_BITS-1:0]           lo_y;
    logic [SEL_BITS-1:0]           lo_z;
    logic [SEL_BITS-1:0]           hi_x;
    logic [SEL_BITS-1:0]           hi_y;
    logic [SEL_BITS-1:0]           hi_z;
  } cfg_t;

  typedef struct packed {
    logic sel_ok;
    logic box_ok;
    logic flat_le;
  } flags_t;

endpackage

// ----- rtl/core/vbe_cfg.sv -----
// Brush configuration register file.
module vbe_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [vbe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [vbe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output vbe_pkg::cfg_t                       cfg
);

  // everything clear except the selection high corner, which opens the full volume
  function automatic vbe_pkg::cfg_t reset_value();
    vbe_pkg::cfg_t c;
    c      = '0;
    c.hi_x = '1;
    c.hi_y = '1;
    c.hi_z = '1;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= reset_value();
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vbe_pkg::REG_CONTROL: begin
          cfg.mode   <= cfg_data[2:0];
          cfg.box    <= cfg_data[3];
          cfg.sel_en <= cfg_data[4];
        end
        vbe_pkg::REG_CENTER: begin
          cfg.cx <= cfg_data[15:0];
          cfg.cy <= cfg_data[31:16];
          cfg.cz <= cfg_data[47:32];
        end
        vbe_pkg::REG_RADIUS: cfg.radius <= cfg_data[14:0];
        vbe_pkg::REG_HALF: begin
          cfg.hx <= cfg_data[14:0];
          cfg.hy <= cfg_data[29:15];
          cfg.hz <= cfg_data[44:30];
        end
        vbe_pkg::REG_FILL: cfg.fill <= {cfg_data[15:0], cfg_data[31:16], cfg_data[39:32]};
        vbe_pkg::REG_FLAT: cfg.flat_h <= cfg_data[10:0];
        vbe_pkg::REG_SEL_LOW: begin
          cfg.lo_x <= cfg_data[9:0];
          cfg.lo_y <= cfg_data[19:10];
          cfg.lo_z <= cfg_data[29:20];
        end
        vbe_pkg::REG_SEL_HIGH: begin
          cfg.hi_x <= cfg_data[9:0];
          cfg.hi_y <= cfg_data[19:10];
          cfg.hi_z <= cfg_data[29:20];
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/vbe_geom.sv -----
// Geometry stages: center deltas, selection and flatten height test, then magnitudes, squares and box test.
module vbe_geom #(
  parameter int COORD_BITS = vbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vbe_pkg::FRAC_BITS_DEF,
  localparam int PW = COORD_BITS + FRAC_BITS,
  localparam int DW = ((PW > vbe_pkg::SIZE_BITS) ? PW : vbe_pkg::SIZE_BITS) + 2,
  localparam int AW = DW - 1,
  localparam int QW = 2 * AW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [COORD_BITS-1:0]          pos_x,
  input  logic [COORD_BITS-1:0]          pos_y,
  input  logic [COORD_BITS-1:0]          pos_z,
  input  vbe_pkg::voxel_t                vox,
  input  vbe_pkg::cfg_t                  cfg,
  output logic                           b_valid,
  output logic [COORD_BITS-1:0]          b_x,
  output logic [COORD_BITS-1:0]          b_y,
  output logic [COORD_BITS-1:0]          b_z,
  output vbe_pkg::voxel_t                b_vox,
  output logic [QW-1:0]                  b_sx,
  output logic [QW-1:0]                  b_sy,
  output logic [QW-1:0]                  b_sz,
  output logic [vbe_pkg::RSQ_BITS-1:0]   b_rsq,
  output vbe_pkg::flags_t                b_flags
);

  localparam int SW = (COORD_BITS > vbe_pkg::SEL_BITS) ? COORD_BITS : vbe_pkg::SEL_BITS;
  localparam int FW = ((COORD_BITS > vbe_pkg::FLAT_BITS) ? COORD_BITS : vbe_pkg::FLAT_BITS) + 1;
  localparam int CB = vbe_pkg::CENTER_BITS;

  // stage A registers
  logic                  a_valid;
  logic [COORD_BITS-1:0] a_x, a_y, a_z;
  vbe_pkg::voxel_t       a_vox;
  logic signed [DW-1:0]  a_dx, a_dy, a_dz;
  logic                  a_sel_ok, a_flat_le;

  logic signed [DW-1:0]  dx_next, dy_next, dz_next;
  logic                  sel_next, flat_next;

  function automatic logic signed [DW-1:0] delta(input logic [COORD_BITS-1:0] p,
                                                  input logic signed [CB-1:0] c);
    logic [PW-1:0] pq;
    pq = PW'(p) << FRAC_BITS;
    return $signed({{(DW-PW){1'b0}}, pq}) - $signed({{(DW-CB){c[CB-1]}}, c});
  endfunction

  function automatic logic in_range(input logic [COORD_BITS-1:0] p,
                                    input logic [vbe_pkg::SEL_BITS-1:0] lo,
                                    input logic [vbe_pkg::SEL_BITS-1:0] hi);
    logic [SW-1:0] pe, le, he;
    pe = SW'(p);
    le = SW'(lo);
    he = SW'(hi);
    return (pe >= le) && (pe <= he);
  endfunction

  always_comb begin
    dx_next  = delta(pos_x, cfg.cx);
    dy_next  = delta(pos_y, cfg.cy);
    dz_next  = delta(pos_z, cfg.cz);
    sel_next = !cfg.sel_en ||
               (in_range(pos_x, cfg.lo_x, cfg.hi_x) &&
                in_range(pos_y, cfg.lo_y, cfg.hi_y) &&
                in_range(pos_z, cfg.lo_z, cfg.hi_z));
    flat_next = $signed({{(FW-COORD_BITS){1'b0}}, pos_y}) <=
                $signed({{(FW-vbe_pkg::FLAT_BITS){cfg.flat_h[vbe_pkg::FLAT_BITS-1]}},
                         cfg.flat_h});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x       <= pos_x;
      a_y       <= pos_y;
      a_z       <= pos_z;
      a_vox     <= vox;
      a_dx      <= dx_next;
      a_dy      <= dy_next;
      a_dz      <= dz_next;
      a_sel_ok  <= sel_next;
      a_flat_le <= flat_next;
    end
  end

  // stage B: magnitudes, squares and box test
  logic [AW-1:0] ax, ay, az;
  logic          box_next;
  logic          flat_mode;

  function automatic logic [AW-1:0] magnitude(input logic signed [DW-1:0] d);
    logic [DW-1:0] n;
    n = -d;
    return d[DW-1] ? n[AW-1:0] : d[AW-1:0];
  endfunction

  always_comb begin
    ax        = magnitude(a_dx);
    ay        = magnitude(a_dy);
    az        = magnitude(a_dz);
    flat_mode = cfg.mode == vbe_pkg::MODE_FLATTEN;
    box_next  = (ax <= AW'(cfg.hx)) && (az <= AW'(cfg.hz)) &&
                (flat_mode || (ay <= AW'(cfg.hy)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x             <= a_x;
      b_y             <= a_y;
      b_z             <= a_z;
      b_vox           <= a_vox;
      b_sx            <= QW'(ax) * QW'(ax);
      b_sy            <= QW'(ay) * QW'(ay);
      b_sz            <= QW'(az) * QW'(az);
      b_rsq           <= vbe_pkg::RSQ_BITS'(cfg.radius) * vbe_pkg::RSQ_BITS'(cfg.radius);
      b_flags.sel_ok  <= a_sel_ok;
      b_flags.box_ok  <= box_next;
      b_flags.flat_le <= a_flat_le;
    end
  end

endmodule

// ----- rtl/core/vbe_edit.sv -----
// Final stage: shape decision, mode edit, change filter and result register.
module vbe_edit #(
  parameter int COORD_BITS = vbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vbe_pkg::FRAC_BITS_DEF,
  localparam int PW = COORD_BITS + FRAC_BITS,
  localparam int DW = ((PW > vbe_pkg::SIZE_BITS) ? PW : vbe_pkg::SIZE_BITS) + 2,
  localparam int QW = 2 * (DW - 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           b_valid,
  input  logic [COORD_BITS-1:0]          b_x,
  input  logic [COORD_BITS-1:0]          b_y,
  input  logic [COORD_BITS-1:0]          b_z,
  input  vbe_pkg::voxel_t                b_vox,
  input  logic [QW-1:0]                  b_sx,
  input  logic [QW-1:0]                  b_sy,
  input  logic [QW-1:0]                  b_sz,
  input  logic [vbe_pkg::RSQ_BITS-1:0]   b_rsq,
  input  vbe_pkg::flags_t                b_flags,
  input  vbe_pkg::cfg_t                  cfg,
  output logic                           out_valid,
  output logic [COORD_BITS-1:0]          out_x,
  output logic [COORD_BITS-1:0]          out_y,
  output logic [COORD_BITS-1:0]          out_z,
  output vbe_pkg::voxel_t                out_old,
  output vbe_pkg::voxel_t                out_new
);

  localparam int SUMW = QW + 2;

  logic [SUMW-1:0]  sum;
  logic             flat_mode, mode_ok, shape_ok, empty, hit, changed;
  vbe_pkg::voxel_t  brush, nv;

  always_comb begin
    flat_mode = cfg.mode == vbe_pkg::MODE_FLATTEN;
    sum       = SUMW'(b_sx) + SUMW'(b_sz) + (flat_mode ? '0 : SUMW'(b_sy));
    shape_ok  = cfg.box ? b_flags.box_ok : (sum <= SUMW'(b_rsq));
    mode_ok   = 1'b1;
    empty     = b_vox.vtype == '0;

    brush = cfg.fill;
    if (cfg.fill.vtype == '0) begin
      brush = '0;
    end

    nv = b_vox;
    unique case (cfg.mode)
      vbe_pkg::MODE_ADD:     if (empty) nv = brush;
      vbe_pkg::MODE_REMOVE:  nv = '0;
      vbe_pkg::MODE_REPLACE: if (!empty) nv = brush;
      // paint takes the raw fill material, even with an empty fill type
      vbe_pkg::MODE_PAINT:   if (!empty) nv.material = cfg.fill.material;
      vbe_pkg::MODE_FLATTEN: nv = b_flags.flat_le ? brush : '0;
      default:               mode_ok = 1'b0;
    endcase
    if (nv.vtype == '0) begin
      nv = '0;
    end

    hit     = mode_ok && b_flags.sel_ok && shape_ok;
    changed = nv != b_vox;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid && hit && changed;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x   <= b_x;
      out_y   <= b_y;
      out_z   <= b_z;
      out_old <= b_vox;
      out_new <= nv;
    end
  end

endmodule

// ----- rtl/core/voxel_brush_edit.sv -----
// Voxel brush edit: one voxel per cycle in, a change request out when the brush alters it.
// Throughput is one voxel per clock while out_ready does not stall the pipeline; a voxel's
// change request passes through three register stages: delta stage loaded at the accepting
// edge, square stage, edit stage holding the result register.
// The three stages move together: while a result waits on out_ready the whole pipeline
// holds and in_ready is low, so in_ready follows out_ready combinationally. Voxels that
// the brush leaves unchanged produce no request. Configuration writes are taken every
// cycle (cfg_ready is always high) and must only be issued while the pipeline is empty.
module voxel_brush_edit #(
  parameter int COORD_BITS = vbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vbe_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vbe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vbe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              pos_x,
  input  logic [COORD_BITS-1:0]              pos_y,
  input  logic [COORD_BITS-1:0]              pos_z,
  input  logic [15:0]                        voxel_type,
  input  logic [15:0]                        voxel_material,
  input  logic [7:0]                         voxel_density,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_BITS-1:0]              out_x,
  output logic [COORD_BITS-1:0]              out_y,
  output logic [COORD_BITS-1:0]              out_z,
  output logic [15:0]                        old_type,
  output logic [15:0]                        old_material,
  output logic [7:0]                         old_density,
  output logic [15:0]                        new_type,
  output logic [15:0]                        new_material,
  output logic [7:0]                         new_density
);

  localparam int PW = COORD_BITS + FRAC_BITS;
  localparam int DW = ((PW > vbe_pkg::SIZE_BITS) ? PW : vbe_pkg::SIZE_BITS) + 2;
  localparam int QW = 2 * (DW - 1);

  vbe_pkg::cfg_t                 cfg;
  vbe_pkg::voxel_t               in_vox, b_vox, out_old, out_new;
  vbe_pkg::flags_t               b_flags;
  logic                          en, b_valid;
  logic [COORD_BITS-1:0]         b_x, b_y, b_z;
  logic [QW-1:0]                 b_sx, b_sy, b_sz;
  logic [vbe_pkg::RSQ_BITS-1:0]  b_rsq;

  // advance every stage unless a result is held
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  assign in_vox = '{vtype: voxel_type, material: voxel_material, density: voxel_density};

  assign old_type     = out_old.vtype;
  assign old_material = out_old.material;
  assign old_density  = out_old.density;
  assign new_type     = out_new.vtype;
  assign new_material = out_new.material;
  assign new_density  = out_new.density;

  vbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vbe_geom #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .vox      (in_vox),
    .cfg      (cfg),
    .b_valid  (b_valid),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .b_vox    (b_vox),
    .b_sx     (b_sx),
    .b_sy     (b_sy),
    .b_sz     (b_sz),
    .b_rsq    (b_rsq),
    .b_flags  (b_flags)
  );

  vbe_edit #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_edit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .b_valid   (b_valid),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .b_vox     (b_vox),
    .b_sx      (b_sx),
    .b_sy      (b_sy),
    .b_sz      (b_sz),
    .b_rsq     (b_rsq),
    .b_flags   (b_flags),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_old   (out_old),
    .out_new   (out_new)
  );

endmodule
